// ===== src/ebd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the edge debouncer with bounce count.
// No dependencies; used by ebd_core and the top level.
package ebd_pkg;

  localparam int TIMER_BITS_DEFAULT = 20;
  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int DEFAULT_TICKS      = 1000;
  localparam int OUT_COUNT_BITS     = 16;
  localparam int ADDR_BITS          = 3;
  localparam int DATA_BITS          = 32;

  localparam logic REG_DEBOUNCE_TICKS = 1'b0;
  localparam logic REG_TRIGGER_MODE   = 1'b1;

  typedef enum logic [1:0] {
    MODE_RISING  = 2'd0,
    MODE_FALLING = 2'd1,
    MODE_NONE    = 2'd2
  } mode_t;

  typedef struct packed {
    logic       mode_wr;
    logic [1:0] mode_value;
  } cfg_wr_t;

  typedef struct packed {
    logic                      fire;
    logic                      expired;
    logic [OUT_COUNT_BITS-1:0] last_bounce_count;
  } result_t;

endpackage

// ===== src/ebd_core.sv =====
`timescale 1ns / 1ps
// Edge detect, retriggerable timeout and bounce counters, one tick per cycle while step is high.
// Depends on ebd_pkg.
module ebd_core #(
  parameter int TIMER_BITS = ebd_pkg::TIMER_BITS_DEFAULT,
  parameter int COUNT_BITS = ebd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  pin_level,
  input  logic [TIMER_BITS-1:0] debounce_ticks,
  input  logic [1:0]            trigger_mode,
  input  ebd_pkg::cfg_wr_t      cfg_wr,
  output ebd_pkg::result_t      result
);

  logic                  previous_level;
  logic                  previous_level_next;
  logic [TIMER_BITS-1:0] timer_remaining;
  logic [TIMER_BITS-1:0] timer_remaining_next;
  logic                  timer_active;
  logic                  timer_active_next;
  logic [COUNT_BITS-1:0] running_count;
  logic [COUNT_BITS-1:0] running_count_next;
  logic [COUNT_BITS-1:0] settled_count;
  logic [COUNT_BITS-1:0] settled_count_next;
  logic [31:0]           settled_ext;
  logic                  edge_seen;
  logic                  at_target;
  logic                  expire;

  always_comb begin
    case (trigger_mode)
      ebd_pkg::MODE_RISING: begin
        edge_seen = !previous_level && pin_level;
        at_target = pin_level;
      end
      ebd_pkg::MODE_FALLING: begin
        edge_seen = previous_level && !pin_level;
        at_target = !pin_level;
      end
      default: begin
        edge_seen = 1'b0;
        at_target = 1'b0;
      end
    endcase
  end

  assign expire = !edge_seen && timer_active && (timer_remaining <= TIMER_BITS'(1));

  always_comb begin
    previous_level_next  = previous_level;
    timer_remaining_next = timer_remaining;
    timer_active_next    = timer_active;
    running_count_next   = running_count;
    settled_count_next   = settled_count;
    if (cfg_wr.mode_wr) begin
      running_count_next = '0;
      settled_count_next = '0;
      if (cfg_wr.mode_value[1]) begin
        timer_active_next    = 1'b0;
        timer_remaining_next = '0;
      end
    end else if (step) begin
      previous_level_next = pin_level;
      if (edge_seen) begin
        if (running_count != {COUNT_BITS{1'b1}}) begin
          running_count_next = running_count + COUNT_BITS'(1);
        end
        timer_remaining_next = debounce_ticks;
        timer_active_next    = 1'b1;
      end else if (expire) begin
        timer_remaining_next = '0;
        timer_active_next    = 1'b0;
        settled_count_next   = running_count;
        running_count_next   = '0;
      end else if (timer_active) begin
        timer_remaining_next = timer_remaining - TIMER_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level  <= 1'b1;
      timer_remaining <= '0;
      timer_active    <= 1'b0;
      running_count   <= '0;
      settled_count   <= '0;
    end else begin
      previous_level  <= previous_level_next;
      timer_remaining <= timer_remaining_next;
      timer_active    <= timer_active_next;
      running_count   <= running_count_next;
      settled_count   <= settled_count_next;
    end
  end

  assign settled_ext = 32'(settled_count_next);

  always_comb begin
    result.fire    = expire && at_target;
    result.expired = expire;
    if (|settled_ext[31:ebd_pkg::OUT_COUNT_BITS]) begin
      result.last_bounce_count = {ebd_pkg::OUT_COUNT_BITS{1'b1}};
    end else begin
      result.last_bounce_count = settled_ext[ebd_pkg::OUT_COUNT_BITS-1:0];
    end
  end

  a_expire_disarms: assert property (@(posedge clk) disable iff (rst)
    step && !cfg_wr.mode_wr && expire |=> !timer_active && running_count == '0)
    else $error("timer still armed after expiry");

  a_edge_arms: assert property (@(posedge clk) disable iff (rst)
    step && !cfg_wr.mode_wr && edge_seen |=> timer_active && running_count != '0)
    else $error("edge did not arm timer");

  a_fire_needs_expire: assert property (@(posedge clk) disable iff (rst)
    result.fire |-> result.expired && timer_active)
    else $error("fire without expiry");

endmodule

// ===== src/edge_debouncer_with_bounce_count_unit.sv =====
`timescale 1ns / 1ps
// Top level: APB register file, debouncer core and two-entry output buffer.
// Depends on ebd_pkg and ebd_core.
//
//  port group  | direction | handshake          | payload
//  ------------+-----------+--------------------+-----------------------------------
//  input       | in        | in_valid/in_stall  | pin_level
//  output      | out       | out_valid/out_stall| fire, expired, last_bounce_count
//  config      | in/out    | psel/penable/pready| paddr, pwdata, prdata
//
// One tick per cycle while in_stall is low; each accepted transaction yields one
// registered result transaction. A skid register behind the output register keeps
// input flowing while out_stall is high; in_stall rises only when both are full.
// Synchronous reset restores debounce_ticks 1000, rising mode, pin high.
module edge_debouncer_with_bounce_count_unit #(
  parameter int TIMER_BITS = ebd_pkg::TIMER_BITS_DEFAULT,
  parameter int COUNT_BITS = ebd_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                pin_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                fire,
  output logic                                expired,
  output logic [ebd_pkg::OUT_COUNT_BITS-1:0]  last_bounce_count,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ebd_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [ebd_pkg::DATA_BITS-1:0]       pwdata,
  output logic [ebd_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready
);

  logic [TIMER_BITS-1:0] debounce_ticks;
  logic [1:0]            trigger_mode;
  logic                  wr_en;
  logic                  step;
  ebd_pkg::cfg_wr_t      cfg_wr;
  ebd_pkg::result_t      result;
  ebd_pkg::result_t      out_data;
  ebd_pkg::result_t      skid_data;
  logic                  skid_valid;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= TIMER_BITS'(ebd_pkg::DEFAULT_TICKS);
      trigger_mode   <= ebd_pkg::MODE_RISING;
    end else if (wr_en) begin
      case (paddr[2])
        ebd_pkg::REG_DEBOUNCE_TICKS: debounce_ticks <= pwdata[TIMER_BITS-1:0];
        ebd_pkg::REG_TRIGGER_MODE:   trigger_mode   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ebd_pkg::REG_DEBOUNCE_TICKS: prdata = ebd_pkg::DATA_BITS'(debounce_ticks);
      ebd_pkg::REG_TRIGGER_MODE:   prdata = ebd_pkg::DATA_BITS'(trigger_mode);
      default:                     prdata = '0;
    endcase
  end

  assign cfg_wr.mode_wr    = wr_en && (paddr[2] == ebd_pkg::REG_TRIGGER_MODE);
  assign cfg_wr.mode_value = pwdata[1:0];

  assign in_stall = skid_valid;
  assign step     = in_valid && !in_stall;

  ebd_core #(
    .TIMER_BITS(TIMER_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .pin_level      (pin_level),
    .debounce_ticks (debounce_ticks),
    .trigger_mode   (trigger_mode),
    .cfg_wr         (cfg_wr),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= step;
        end
      end else if (step) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (step) begin
        out_data <= result;
      end
    end else if (step) begin
      skid_data <= result;
    end
  end

  assign fire              = out_data.fire;
  assign expired           = out_data.expired;
  assign last_bounce_count = out_data.last_bounce_count;

endmodule

// ===== tb/edge_debouncer_with_bounce_count_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the edge debouncer with bounce count: random pin bursts,
// APB register changes and output stalls, checked against an in-bench debouncer.
// Depends on ebd_pkg and edge_debouncer_with_bounce_count_unit.
module edge_debouncer_with_bounce_count_unit_tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 80;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [ebd_pkg::ADDR_BITS-1:0] ADDR_TICKS = {ebd_pkg::REG_DEBOUNCE_TICKS, 2'b00};
  localparam logic [ebd_pkg::ADDR_BITS-1:0] ADDR_MODE  = {ebd_pkg::REG_TRIGGER_MODE, 2'b00};
  localparam logic [ebd_pkg::TIMER_BITS_DEFAULT-1:0] TICKS_MAX = '1;
  localparam logic [ebd_pkg::COUNT_BITS_DEFAULT-1:0] COUNT_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic pin_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic fire;
  logic expired;
  logic [ebd_pkg::OUT_COUNT_BITS-1:0] last_bounce_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ebd_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [ebd_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [ebd_pkg::DATA_BITS-1:0] prdata;
  logic pready;

  edge_debouncer_with_bounce_count_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pin_level(pin_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .fire(fire), .expired(expired), .last_bounce_count(last_bounce_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // debouncer state and register copies
  logic [ebd_pkg::TIMER_BITS_DEFAULT-1:0] cfg_ticks;
  logic [1:0]                             cfg_mode;
  logic                                   last_pin;
  logic [ebd_pkg::TIMER_BITS_DEFAULT-1:0] countdown;
  logic                                   countdown_armed;
  logic [ebd_pkg::COUNT_BITS_DEFAULT-1:0] burst_edges;
  logic [ebd_pkg::COUNT_BITS_DEFAULT-1:0] settled_edges;

  logic             pin_backlog[$];
  ebd_pkg::result_t predicted_outputs[$];

  int errors = 0;
  int cycles = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int fires_seen = 0;
  int expiries_seen = 0;
  int peak_settled = 0;
  int holds_asked = 0;
  int holds_done = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  function automatic ebd_pkg::result_t debounce_tick(input logic level);
    ebd_pkg::result_t r;
    logic hit;
    r = '0;
    hit = 1'b0;
    if (cfg_mode == ebd_pkg::MODE_RISING) hit = !last_pin && level;
    else if (cfg_mode == ebd_pkg::MODE_FALLING) hit = last_pin && !level;
    if (hit) begin
      if (burst_edges != COUNT_MAX) burst_edges++;
      countdown = cfg_ticks;
      countdown_armed = 1'b1;
    end else if (countdown_armed) begin
      if (countdown <= 1) begin
        countdown = '0;
        countdown_armed = 1'b0;
        r.expired = 1'b1;
        settled_edges = burst_edges;
        burst_edges = '0;
        if (cfg_mode == ebd_pkg::MODE_RISING) r.fire = level;
        else if (cfg_mode == ebd_pkg::MODE_FALLING) r.fire = !level;
      end else begin
        countdown--;
      end
    end
    last_pin = level;
    r.last_bounce_count = settled_edges;
    return r;
  endfunction

  task automatic report_field(input string field, input int wanted, input int got);
    errors++;
    if (errors <= 30)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, wanted, got);
  endtask

  // driver: one pin sample per transaction
  bit took;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      pin_level <= 1'b0;
      gap_left = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        predicted_outputs.push_back(debounce_tick(pin_level));
        ticks_sent++;
        gap_left = send_calm ? 0 : $urandom_range(0, 7);
      end
      if (!in_valid || took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pin_backlog.size() > 0) begin
          pin_level <= pin_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transaction, stall at random
  ebd_pkg::result_t wanted;
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual fire %0b expired %0b count %0d",
                   $time, fire, expired, last_bounce_count);
        end else begin
          wanted = predicted_outputs.pop_front();
          results_checked++;
          if (wanted.fire) fires_seen++;
          if (wanted.expired) expiries_seen++;
          if (int'(wanted.last_bounce_count) > peak_settled)
            peak_settled = int'(wanted.last_bounce_count);
          if (fire !== wanted.fire) report_field("fire", int'(wanted.fire), int'(fire));
          if (expired !== wanted.expired)
            report_field("expired", int'(wanted.expired), int'(expired));
          if (last_bounce_count !== wanted.last_bounce_count)
            report_field("last_bounce_count", int'(wanted.last_bounce_count),
                         int'(last_bounce_count));
        end
        stall_left = recv_calm ? 0 : $urandom_range(0, 7);
      end
      if (holds_asked != holds_done) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("edge_debouncer_with_bounce_count_unit test failed");
      $finish;
    end
  end

  task automatic apb_write(input logic [ebd_pkg::ADDR_BITS-1:0] a,
                           input logic [ebd_pkg::DATA_BITS-1:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(input logic [ebd_pkg::ADDR_BITS-1:0] a,
                          output logic [ebd_pkg::DATA_BITS-1:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    d = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_registers();
    logic [ebd_pkg::DATA_BITS-1:0] got;
    apb_read(ADDR_TICKS, got);
    if (got[ebd_pkg::TIMER_BITS_DEFAULT-1:0] !== cfg_ticks)
      report_field("debounce_ticks readback", int'(cfg_ticks),
                   int'(got[ebd_pkg::TIMER_BITS_DEFAULT-1:0]));
    apb_read(ADDR_MODE, got);
    if (got[1:0] !== cfg_mode)
      report_field("trigger_mode readback", int'(cfg_mode), int'(got[1:0]));
  endtask

  task automatic write_ticks(input logic [ebd_pkg::TIMER_BITS_DEFAULT-1:0] v);
    apb_write(ADDR_TICKS, ebd_pkg::DATA_BITS'(v));
    cfg_ticks = v;
  endtask

  // a mode write clears both counts; none and unused also disarm the timer
  task automatic write_mode(input logic [1:0] m);
    apb_write(ADDR_MODE, ebd_pkg::DATA_BITS'(m));
    cfg_mode = m;
    burst_edges = '0;
    settled_edges = '0;
    if (m >= ebd_pkg::MODE_NONE) begin
      countdown_armed = 1'b0;
      countdown = '0;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pin_backlog.size() != 0 || in_valid || predicted_outputs.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic send_levels(input logic [31:0] bits, input int n);
    @(negedge clk);
    for (int i = n - 1; i >= 0; i--) pin_backlog.push_back(bits[i]);
    wait_drained();
  endtask

  // bounce bursts followed by a settled run, mixed with plain noise
  task automatic queue_bouncy(input int count, input int settle);
    int added;
    int run;
    logic lvl;
    added = 0;
    while (added < count) begin
      run = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 10 : 6);
      repeat (run) pin_backlog.push_back(1'($urandom_range(0, 1)));
      added += run;
      if ($urandom_range(0, 4) != 0) begin
        lvl = 1'($urandom_range(0, 1));
        run = (settle > 30 ? 30 : settle) + $urandom_range(1, 4);
        repeat (run) pin_backlog.push_back(lvl);
        added += run;
      end
    end
  endtask

  initial begin
    int tick_pick;
    logic [1:0] mode_pick;
    cfg_ticks = ebd_pkg::TIMER_BITS_DEFAULT'(ebd_pkg::DEFAULT_TICKS);
    cfg_mode = ebd_pkg::MODE_RISING;
    last_pin = 1'b1;
    countdown = '0;
    countdown_armed = 1'b0;
    burst_edges = '0;
    settled_edges = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: reset values, zero settling, edge on expiry, falling, none, unused
    check_registers();
    send_levels(32'b011, 3);
    write_ticks('0);
    write_mode(ebd_pkg::MODE_RISING);
    check_registers();
    send_levels(32'b01011, 5);
    write_ticks(ebd_pkg::TIMER_BITS_DEFAULT'(2));
    send_levels(32'b010111, 6);
    write_ticks(ebd_pkg::TIMER_BITS_DEFAULT'(1));
    write_mode(ebd_pkg::MODE_FALLING);
    send_levels(32'b101001, 6);
    write_ticks(ebd_pkg::TIMER_BITS_DEFAULT'(5));
    send_levels(32'b10, 2);
    write_mode(ebd_pkg::MODE_NONE);
    check_registers();
    send_levels(32'b01, 2);
    write_mode(MODE_UNUSED);
    check_registers();
    send_levels(32'b10, 2);
    write_ticks(TICKS_MAX);
    write_mode(ebd_pkg::MODE_RISING);
    check_registers();
    send_levels(32'b01, 2);

    // random phases
    for (int p = 0; p < 12; p++) begin
      if (p == 5) tick_pick = int'(TICKS_MAX);
      else if (p == 6) tick_pick = 0;
      else if ($urandom_range(0, 3) == 0) tick_pick = $urandom_range(0, 40);
      else tick_pick = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mode_pick = ebd_pkg::MODE_RISING;
        4, 5, 6, 7: mode_pick = ebd_pkg::MODE_FALLING;
        8:          mode_pick = ebd_pkg::MODE_NONE;
        default:    mode_pick = MODE_UNUSED;
      endcase
      if ($urandom_range(0, 1) == 0) begin
        if (p < 2 || $urandom_range(0, 2) != 0)
          write_ticks(ebd_pkg::TIMER_BITS_DEFAULT'(tick_pick));
        if (p < 2 || $urandom_range(0, 3) != 0) write_mode(mode_pick);
      end else begin
        if (p < 2 || $urandom_range(0, 3) != 0) write_mode(mode_pick);
        if (p < 2 || $urandom_range(0, 2) != 0)
          write_ticks(ebd_pkg::TIMER_BITS_DEFAULT'(tick_pick));
      end
      if (p % 4 == 0) check_registers();
      @(negedge clk);
      send_calm = (p % 4 == 1) || p == 3 || p == 8;
      recv_calm = (p % 4 == 2);
      if (p == 3 || p == 8) holds_asked++;
      queue_bouncy(115, int'(cfg_ticks));
      wait_drained();
    end

    repeat (10) @(negedge clk);

    $display("Checked %0d results from %0d pin ticks: %0d expiries, %0d fires.",
             results_checked, ticks_sent, expiries_seen, fires_seen);
    $display("All trigger modes, settling times 0 to max and long output holds (peak %0d).",
             peak_settled);
    if (errors == 0) begin
      $display("edge_debouncer_with_bounce_count_unit test passed");
    end else begin
      $display("edge_debouncer_with_bounce_count_unit test failed");
    end
    $finish;
  end

endmodule

// ===== edge_debouncer_with_bounce_count_unit.f =====
src/ebd_pkg.sv
src/ebd_core.sv
src/edge_debouncer_with_bounce_count_unit.sv
tb/edge_debouncer_with_bounce_count_unit_tb.sv
